>>> sv/sha256_digest_engine_core_macros.svh
// Assertion helpers shared by the engine's RTL files.
// Each expects clk and rst_n in scope.
`ifndef SHA256_DIGEST_ENGINE_CORE_MACROS_SVH
`define SHA256_DIGEST_ENGINE_CORE_MACROS_SVH

// same-cycle implication
`define SDE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SDE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/sde_pkg.sv
`default_nettype none

package sde_pkg;

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [5:0] BLOCK_LAST = 6'd63;
  localparam logic [5:0] LEN_POS    = 6'd56;
  localparam logic [5:0] ROUND_LAST = 6'd63;
  localparam logic [2:0] WORD_LAST  = 3'd7;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD80,
    ST_PADZ,
    ST_PADLEN,
    ST_PRIME,
    ST_ROUND,
    ST_FOLD
  } state_t;

  typedef enum logic [1:0] {
    SEL_MSG,
    SEL_PAD,
    SEL_ZERO,
    SEL_LEN
  } byte_sel_t;

  typedef struct packed {
    logic      push;        // shift one byte into the block
    byte_sel_t byte_sel;
    logic      prime;       // load working vars, first schedule step
    logic      round;       // one compression round
    logic      fold;        // add working vars into chain
    logic      fold_final;  // fold goes to output buffer, chain restarts
  } ctrl_cmd_t;

  typedef struct packed {
    logic pos_last;   // next byte completes the block
    logic pos_len;    // next byte is the first length byte
    logic rnd_last;   // current round is the 64th
    logic out_busy;   // digest buffer still draining
  } dp_stat_t;

endpackage

`default_nettype wire

>>> sv/sde_ctrl.sv
`default_nettype none

`include "sha256_digest_engine_core_macros.svh"

module sde_ctrl
  import sde_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  input  wire        in_present,
  input  wire        in_last,
  output logic       in_tready,
  input  dp_stat_t   stat,
  output ctrl_cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   eom_r, eom_nxt;   // end of message seen
  logic   pad_r, pad_nxt;   // 0x80 byte already pushed
  logic   len_r, len_nxt;   // length block pushed

  logic   final_done;
  assign final_done = (state_r == ST_FOLD) && len_r && !stat.out_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      eom_r   <= 1'b0;
      pad_r   <= 1'b0;
      len_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      eom_r   <= eom_nxt;
      pad_r   <= pad_nxt;
      len_r   <= len_nxt;
    end
  end

  // next state and phase flags
  always_comb begin
    state_nxt = state_r;
    eom_nxt   = eom_r;
    pad_nxt   = pad_r;
    len_nxt   = len_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          eom_nxt = in_last;
          if (in_present && stat.pos_last) begin
            state_nxt = ST_PRIME;
          end else if (in_last) begin
            state_nxt = ST_PAD80;
          end
        end
      end
      ST_PAD80: begin
        pad_nxt   = 1'b1;
        state_nxt = stat.pos_last ? ST_PRIME : ST_PADZ;
      end
      ST_PADZ: begin
        if (stat.pos_len) begin
          state_nxt = ST_PADLEN;
        end else if (stat.pos_last) begin
          state_nxt = ST_PRIME;
        end
      end
      ST_PADLEN: begin
        if (stat.pos_last) begin
          len_nxt   = 1'b1;
          state_nxt = ST_PRIME;
        end
      end
      ST_PRIME: begin
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        if (stat.rnd_last) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        if (len_r) begin
          if (!stat.out_busy) begin
            state_nxt = ST_IDLE;
            eom_nxt   = 1'b0;
            pad_nxt   = 1'b0;
            len_nxt   = 1'b0;
          end
        end else if (eom_r && !pad_r) begin
          state_nxt = ST_PAD80;
        end else if (pad_r) begin
          state_nxt = ST_PADZ;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // commands
  always_comb begin
    in_tready      = 1'b0;
    cmd.push       = 1'b0;
    cmd.byte_sel   = SEL_MSG;
    cmd.prime      = 1'b0;
    cmd.round      = 1'b0;
    cmd.fold       = 1'b0;
    cmd.fold_final = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.push  = in_tvalid && in_present;
      end
      ST_PAD80: begin
        cmd.push     = 1'b1;
        cmd.byte_sel = SEL_PAD;
      end
      ST_PADZ: begin
        cmd.push     = !stat.pos_len;
        cmd.byte_sel = SEL_ZERO;
      end
      ST_PADLEN: begin
        cmd.push     = 1'b1;
        cmd.byte_sel = SEL_LEN;
      end
      ST_PRIME: begin
        cmd.prime = 1'b1;
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
      end
      ST_FOLD: begin
        cmd.fold       = !(len_r && stat.out_busy);
        cmd.fold_final = len_r;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  `SDE_ASSERT_NOW(a_push_not_round, cmd.push, !cmd.round && !cmd.prime, "push during compression")
  `SDE_ASSERT_NEXT(a_round_to_fold, (state_r == ST_ROUND) && stat.rnd_last, state_r == ST_FOLD, "rounds did not end in fold")
  `SDE_ASSERT_NOW(a_fold_waits, (state_r == ST_FOLD) && len_r && stat.out_busy, !cmd.fold, "digest folded over busy buffer")
  `SDE_ASSERT_NEXT(a_flags_clear, final_done, !eom_r && !pad_r && !len_r, "phase flags kept after digest")

endmodule

`default_nettype wire

>>> sv/sde_dpath.sv
`default_nettype none

`include "sha256_digest_engine_core_macros.svh"

module sde_dpath
  import sde_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  input  ctrl_cmd_t   cmd,
  input  wire  [7:0]  in_byte,
  output dp_stat_t    stat,
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [31:0] out_tdata,
  output logic [2:0]  out_tuser,
  output logic        out_tlast
);

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  // control-side counters
  logic [60:0] cnt_r, cnt_nxt;   // message bytes, wraps
  logic [5:0]  pos_r, pos_nxt;   // byte position in block
  logic [5:0]  rnd_r, rnd_nxt;

  // payload
  logic [31:0] chain_r [8];
  logic [31:0] wv_r    [8];      // a..h
  logic [31:0] win_r   [16];     // schedule window, [0] oldest
  logic [23:0] acc_r;            // partial word, upper bytes
  logic [31:0] wk_r;             // W + K for the current round

  // digest buffer
  logic [31:0] obuf_r [8];
  logic [2:0]  oidx_r;
  logic        ovalid_r;
  logic        out_fire;

  logic [7:0]  push_byte;
  logic [63:0] len_bits;
  logic [31:0] push_word;
  logic [5:0]  step_idx;
  logic [31:0] w_step;
  logic [31:0] t1, t2;
  logic [31:0] sum_w [8];

  assign len_bits  = {cnt_r, 3'b000};
  assign push_word = {acc_r, push_byte};
  assign out_fire  = ovalid_r && out_tready;

  always_comb begin
    case (cmd.byte_sel)
      SEL_MSG:  push_byte = in_byte;
      SEL_PAD:  push_byte = PAD_BYTE;
      SEL_ZERO: push_byte = 8'h00;
      SEL_LEN:  push_byte = len_bits[{~pos_r[2:0], 3'b000} +: 8];
      default:  push_byte = 8'h00;
    endcase
  end

  // schedule step runs one ahead of the rounds
  assign step_idx = cmd.prime ? 6'd0 : rnd_r + 6'd1;
  assign w_step   = (step_idx[5:4] == 2'b00) ? win_r[0]
                  : ssig1(win_r[14]) + win_r[9] + ssig0(win_r[1]) + win_r[0];

  assign t1 = wv_r[7] + bsig1(wv_r[4]) + ((wv_r[4] & wv_r[5]) ^ (~wv_r[4] & wv_r[6])) + wk_r;
  assign t2 = bsig0(wv_r[0]) + ((wv_r[0] & wv_r[1]) ^ (wv_r[0] & wv_r[2]) ^ (wv_r[1] & wv_r[2]));

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      sum_w[i] = chain_r[i] + wv_r[i];
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    pos_nxt = pos_r;
    rnd_nxt = rnd_r;
    if (cmd.push) begin
      pos_nxt = pos_r + 6'd1;
      if (cmd.byte_sel == SEL_MSG) begin
        cnt_nxt = cnt_r + 61'd1;
      end
    end
    if (cmd.prime) begin
      rnd_nxt = 6'd0;
    end else if (cmd.round) begin
      rnd_nxt = rnd_r + 6'd1;
    end
    if (cmd.fold && cmd.fold_final) begin
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      pos_r <= '0;
      rnd_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      pos_r <= pos_nxt;
      rnd_r <= rnd_nxt;
    end
  end

  // chaining words restart from the initial values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        chain_r[i] <= INIT_H[i];
      end
    end else if (cmd.fold) begin
      for (int i = 0; i < 8; i++) begin
        chain_r[i] <= cmd.fold_final ? INIT_H[i] : sum_w[i];
      end
    end
  end

  // byte packing and schedule window
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      acc_r <= push_word[23:0];
      if (pos_r[1:0] == 2'b11) begin
        for (int i = 0; i < 15; i++) begin
          win_r[i] <= win_r[i + 1];
        end
        win_r[15] <= push_word;
      end
    end else if (cmd.prime || cmd.round) begin
      for (int i = 0; i < 15; i++) begin
        win_r[i] <= win_r[i + 1];
      end
      win_r[15] <= w_step;
      wk_r      <= w_step + ROUND_K[step_idx];
    end
  end

  // working variables
  always_ff @(posedge clk) begin
    if (cmd.prime) begin
      for (int i = 0; i < 8; i++) begin
        wv_r[i] <= chain_r[i];
      end
    end else if (cmd.round) begin
      wv_r[7] <= wv_r[6];
      wv_r[6] <= wv_r[5];
      wv_r[5] <= wv_r[4];
      wv_r[4] <= wv_r[3] + t1;
      wv_r[3] <= wv_r[2];
      wv_r[2] <= wv_r[1];
      wv_r[1] <= wv_r[0];
      wv_r[0] <= t1 + t2;
    end
  end

  // digest buffer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
      oidx_r   <= '0;
    end else if (cmd.fold && cmd.fold_final) begin
      ovalid_r <= 1'b1;
      oidx_r   <= '0;
    end else if (out_fire) begin
      oidx_r <= oidx_r + 3'd1;
      if (oidx_r == WORD_LAST) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fold && cmd.fold_final) begin
      for (int i = 0; i < 8; i++) begin
        obuf_r[i] <= sum_w[i];
      end
    end else if (out_fire) begin
      for (int i = 0; i < 7; i++) begin
        obuf_r[i] <= obuf_r[i + 1];
      end
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = obuf_r[0];
  assign out_tuser  = oidx_r;
  assign out_tlast  = (oidx_r == WORD_LAST);

  assign stat.pos_last = (pos_r == BLOCK_LAST);
  assign stat.pos_len  = (pos_r == LEN_POS);
  assign stat.rnd_last = (rnd_r == ROUND_LAST);
  assign stat.out_busy = ovalid_r;

  `SDE_ASSERT_NOW(a_final_on_boundary, cmd.fold && cmd.fold_final, pos_r == 6'd0 && !ovalid_r, "final fold off block boundary or buffer busy")
  `SDE_ASSERT_NOW(a_no_push_in_rounds, cmd.round || cmd.prime, !cmd.push && !cmd.fold, "datapath commands overlap")
  `SDE_ASSERT_NEXT(a_last_word_drains, out_fire && out_tlast, !ovalid_r, "buffer valid after last word")

endmodule

`default_nettype wire

>>> sv/sha256_digest_engine_core.sv
// SHA-256 engine, byte-streaming.
// Input channel (in_*): one transaction per message byte. in_tuser marks that
// in_tdata carries a byte; in_tlast closes the message, after its byte if any.
// A transaction with in_tlast and no byte is allowed, so empty messages work.
// Output channel (out_*): eight transactions per message, digest word 0 (most
// significant) first; out_tuser is the word index and out_tlast marks word 7.
// Intake: bytes are accepted back to back while in_tready is high; every 64th
// byte starts a compression (a load/schedule step, the 64 rounds and a fold)
// during which in_tready is low. Finish: padding is pushed one byte per cycle
// up to the block end, with an idle step before the length bytes; then one or
// two compressions run; the digest is valid the cycle after the last fold and
// drains at one word per cycle while out_tready is high.
// The digest sits in its own 8-word buffer, so the next message streams in
// while the receiver stalls; only a second finish waits for the buffer.
// Reset (rst_n low, synchronous): chaining words go to the initial hash values,
// the byte count clears and the output buffer empties.
`default_nettype none

module sha256_digest_engine_core
  import sde_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  // message bytes
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,    // [7:0] data_byte
  input  wire         in_tuser,    // [0] byte_present
  input  wire         in_tlast,    // end_of_message
  // digest words
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [31:0] out_tdata,   // [31:0] digest_word
  output logic [2:0]  out_tuser,   // [2:0] word_index
  output logic        out_tlast    // last_word
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // sequencing: byte intake, padding phases, round count, digest handoff
  sde_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_present (in_tuser),
    .in_last    (in_tlast),
    .in_tready  (in_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // block packing, message schedule, round logic, chain and digest buffer
  sde_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_byte    (in_tdata),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire
